[hdl/cms_pkg.sv]
// Shared types, codes and constants for the counted multiset table.
package cms_pkg;

    // Default number of table entries
    localparam int CAPACITY_DEF = 64;

    // Field widths
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 16;
    localparam int AMOUNT_W   = 16;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_W    = 22;
    localparam int DISTINCT_W = 7;

    // Saturation value of one entry count
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Command codes; the unused code acts as a query
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    // Update broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SET,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd            cmd;
        logic [VALUE_W-1:0]   value;
        logic [COUNT_W-1:0]   count;
    } t_cell_op;

endpackage

[hdl/counted_multiset_table.sv]
// Top level of the counted multiset table: control, gather and result register.
//
// Usage: commands enter on the slave stream (s_axis_*) and each one yields exactly one
// result on the master stream (m_axis_*). s_axis_tuser carries the command (add,
// remove, query); s_axis_tdata carries the value and the amount. m_axis_tuser carries
// the status; m_axis_tdata carries presence, the value's count, the total of all
// occurrences, the number of distinct values and the empty flag.
// Each command passes a lookup state and then an update state. The lookup compares
// the key in every cell of the chain and gathers the match; the update changes the matching
// cell, writes the next free cell, or shifts the cells above a freed entry one place
// down. The next command is taken during that update, unless the output register is
// stalled, so a new command can enter before the last one is through.
// Entries are kept packed at the low end of the chain, so the free entry is always
// the one at the occupied count.
// Reset clears all valid marks, the total and the distinct count at once; there is
// no clearing pass. When the receiver stalls, the result waits in the output
// register, the update of the next command holds, and s_axis_tready drops.
module counted_multiset_table #(
    parameter int CAPACITY = cms_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // value[31:0], amount[47:32]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // present[0], value_count[16:1],
                                        // total_count[38:17], distinct_count[45:39],
                                        // is_empty[46], zero[47]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int TOT_W = $clog2(CAPACITY) + cms_pkg::COUNT_W + 1;
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

    // Sequencer
    cms_pkg::t_state r_state, n_state;

    // Command held from acceptance through the update
    logic [cms_pkg::CMD_W-1:0]    r_cmd;
    logic [cms_pkg::VALUE_W-1:0]  r_value;
    logic [cms_pkg::AMOUNT_W-1:0] r_amount;

    // Gathered lookup result
    logic                        r_hit;
    logic [cms_pkg::COUNT_W-1:0] r_hit_count;
    logic [IDX_W-1:0]            r_hit_idx;

    // Table totals
    logic [TOT_W-1:0] r_total, n_total;
    logic [OCC_W-1:0] r_occ, n_occ;

    // Result register
    logic                          r_out_valid;
    logic [cms_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic                          r_out_present, n_out_present;
    logic [cms_pkg::COUNT_W-1:0]   r_out_count, n_out_count;

    logic in_fire;
    logic upd_fire;
    logic out_free;

    // Cell chain wiring
    cms_pkg::t_cell_op            cell_op;
    logic [IDX_W-1:0]             cell_sel;
    logic [cms_pkg::VALUE_W-1:0]  c_value [CAPACITY+1];
    logic [cms_pkg::COUNT_W-1:0]  c_count [CAPACITY+1];
    logic                         c_valid [CAPACITY+1];
    logic                         c_match [CAPACITY];

    // Gather wires
    logic                        g_hit;
    logic [cms_pkg::COUNT_W-1:0] g_count;
    logic [IDX_W-1:0]            g_idx;

    // Update arithmetic
    logic [cms_pkg::COUNT_W:0]   add_sum;
    logic [cms_pkg::COUNT_W-1:0] add_new;
    logic [cms_pkg::COUNT_W-1:0] add_delta;
    logic [cms_pkg::COUNT_W-1:0] sub_new;

    // Wide views for masking to field widths
    logic [63:0] total_wide;
    logic [63:0] occ_wide;

    // Handshakes
    assign out_free      = !r_out_valid || m_axis_tready;
    assign upd_fire      = (r_state == cms_pkg::ST_UPDATE) && out_free;
    assign s_axis_tready = (r_state == cms_pkg::ST_IDLE) || upd_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Terminate the chain with an empty entry
    assign c_value[CAPACITY] = '0;
    assign c_count[CAPACITY] = '0;
    assign c_valid[CAPACITY] = 1'b0;

    // Row of entry cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        cms_cell #(
            .IDX   (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_key      (r_value),
            .i_op       (cell_op),
            .i_sel_idx  (cell_sel),
            .i_nb_value (c_value[g+1]),
            .i_nb_count (c_count[g+1]),
            .i_nb_valid (c_valid[g+1]),
            .o_value    (c_value[g]),
            .o_count    (c_count[g]),
            .o_valid    (c_valid[g]),
            .o_match    (c_match[g])
        );
    end

    // Gather the single match across the cells
    always_comb begin
        g_hit   = 1'b0;
        g_count = '0;
        g_idx   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            g_hit   = g_hit | c_match[i];
            g_count = g_count | (c_match[i] ? c_count[i] : '0);
            g_idx   = g_idx | (c_match[i] ? IDX_W'(i) : '0);
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cms_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cms_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = cms_pkg::ST_LOOKUP;
                end
            end
            cms_pkg::ST_LOOKUP: begin
                n_state = cms_pkg::ST_UPDATE;
            end
            cms_pkg::ST_UPDATE: begin
                if (upd_fire) begin
                    n_state = in_fire ? cms_pkg::ST_LOOKUP : cms_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cms_pkg::ST_IDLE;
            end
        endcase
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd    <= s_axis_tuser;
            r_value  <= s_axis_tdata[31:0];
            r_amount <= s_axis_tdata[47:32];
        end
    end

    // Hold the gathered match for the update cycle
    always_ff @(posedge i_clk) begin
        if (r_state == cms_pkg::ST_LOOKUP) begin
            r_hit       <= g_hit;
            r_hit_count <= g_count;
            r_hit_idx   <= g_idx;
        end
    end

    // Saturating add and plain subtract of the stored count
    assign add_sum   = {1'b0, r_hit_count} + {1'b0, r_amount};
    assign add_new   = add_sum[cms_pkg::COUNT_W] ? cms_pkg::COUNT_MAX
                                                 : add_sum[cms_pkg::COUNT_W-1:0];
    assign add_delta = add_new - r_hit_count;
    assign sub_new   = r_hit_count - r_amount;

    // Decide the update and the result
    always_comb begin
        cell_op.cmd   = cms_pkg::CELL_HOLD;
        cell_op.value = r_value;
        cell_op.count = add_new;
        cell_sel      = r_hit_idx;
        n_total       = r_total;
        n_occ         = r_occ;
        n_out_status  = cms_pkg::STAT_DONE;
        n_out_present = r_hit;
        n_out_count   = r_hit ? r_hit_count : '0;
        unique case (r_cmd)
            cms_pkg::CMD_ADD: begin
                if (r_amount != '0) begin
                    if (r_hit) begin
                        cell_op.cmd = cms_pkg::CELL_SET;
                        n_total     = r_total + TOT_W'(add_delta);
                        n_out_count = add_new;
                    end else if (r_occ == OCC_FULL) begin
                        n_out_status = cms_pkg::STAT_FULL;
                    end else begin
                        cell_op.cmd   = cms_pkg::CELL_INSERT;
                        cell_op.count = r_amount;
                        cell_sel      = r_occ[IDX_W-1:0];
                        n_total       = r_total + TOT_W'(r_amount);
                        n_occ         = r_occ + OCC_W'(1);
                        n_out_present = 1'b1;
                        n_out_count   = r_amount;
                    end
                end
            end
            cms_pkg::CMD_REMOVE: begin
                if (!r_hit) begin
                    n_out_status = cms_pkg::STAT_ABSENT;
                end else if (r_hit_count > r_amount) begin
                    cell_op.cmd   = cms_pkg::CELL_SET;
                    cell_op.count = sub_new;
                    n_total       = r_total - TOT_W'(r_amount);
                    n_out_count   = sub_new;
                end else begin
                    cell_op.cmd   = cms_pkg::CELL_REMOVE;
                    n_total       = r_total - TOT_W'(r_hit_count);
                    n_occ         = r_occ - OCC_W'(1);
                    n_out_present = 1'b0;
                    n_out_count   = '0;
                end
            end
            default: begin
            end
        endcase
        if (!upd_fire) begin
            cell_op.cmd = cms_pkg::CELL_HOLD;
        end
    end

    // Table totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_occ   <= '0;
        end else if (upd_fire) begin
            r_total <= n_total;
            r_occ   <= n_occ;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_out_status  <= n_out_status;
            r_out_present <= n_out_present;
            r_out_count   <= n_out_count;
        end
    end

    // Totals are reported from the live registers, which hold while a result waits
    assign total_wide = 64'(r_total);
    assign occ_wide   = 64'(r_occ);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0,
                            (r_occ == '0),
                            occ_wide[cms_pkg::DISTINCT_W-1:0],
                            total_wide[cms_pkg::TOTAL_W-1:0],
                            r_out_count,
                            r_out_present};

    // Occupied count never passes the capacity
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_FULL)
        else $error("occupied count above capacity");

    // An empty table holds no occurrences
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> (r_total == '0))
        else $error("occurrences counted in an empty table");

    // An accepted transaction always starts a lookup
    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == cms_pkg::ST_LOOKUP))
        else $error("accepted transaction did not start a lookup");

    // One update changes the occupied count by at most one
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == $past(r_occ)) || (r_occ == $past(r_occ) + OCC_W'(1))
        || (r_occ == $past(r_occ) - OCC_W'(1)))
        else $error("occupied count moved by more than one");

    // A new result is written only into a free or draining output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_count)))
        else $error("waiting result overwritten");

endmodule

[hdl/cms_cell.sv]
// One table entry of the compacted chain: value, count and valid mark.
module cms_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [cms_pkg::VALUE_W-1:0]    i_key,
    input  cms_pkg::t_cell_op              i_op,
    input  logic [IDX_W-1:0]               i_sel_idx,
    input  logic [cms_pkg::VALUE_W-1:0]    i_nb_value,
    input  logic [cms_pkg::COUNT_W-1:0]    i_nb_count,
    input  logic                           i_nb_valid,
    output logic [cms_pkg::VALUE_W-1:0]    o_value,
    output logic [cms_pkg::COUNT_W-1:0]    o_count,
    output logic                           o_valid,
    output logic                           o_match
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [cms_pkg::VALUE_W-1:0] r_value, n_value;
    logic [cms_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_valid, n_valid;
    logic                        sel_here;
    logic                        at_or_above;

    assign sel_here    = (i_sel_idx == MY_IDX);
    assign at_or_above = (MY_IDX >= i_sel_idx);

    // Compare the broadcast key against this entry
    assign o_match = r_valid && (r_value == i_key);

    // Apply the broadcast update; a removal pulls the right neighbor in
    always_comb begin
        n_value = r_value;
        n_count = r_count;
        n_valid = r_valid;
        unique case (i_op.cmd)
            cms_pkg::CELL_HOLD: begin
            end
            cms_pkg::CELL_SET: begin
                if (sel_here) begin
                    n_count = i_op.count;
                end
            end
            cms_pkg::CELL_INSERT: begin
                if (sel_here) begin
                    n_value = i_op.value;
                    n_count = i_op.count;
                    n_valid = 1'b1;
                end
            end
            cms_pkg::CELL_REMOVE: begin
                if (at_or_above) begin
                    n_value = i_nb_value;
                    n_count = i_nb_count;
                    n_valid = i_nb_valid;
                end
            end
            default: begin
            end
        endcase
    end

    // Valid mark, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_count <= n_count;
    end

    assign o_value = r_value;
    assign o_count = r_count;
    assign o_valid = r_valid;

endmodule
